// ----- src/fbr_pkg.sv -----
// package: types, constants and codes for the page frame buffer refresh block
package fbr_pkg;

  localparam int WIDTH = 128;
  localparam int PAGES = 8;

  localparam int HEADER_LEN = 3;
  localparam int CW = $clog2(WIDTH);
  localparam int PG_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW = PG_W + CW;
  localparam int DEPTH = 2 ** AW;
  localparam int POS_W = $clog2(HEADER_LEN + WIDTH);

  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_LOW = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;

  typedef enum logic [1:0] {
    FUNC_SET       = 2'd0,
    FUNC_CLR       = 2'd1,
    FUNC_CLEAR_ALL = 2'd2,
    FUNC_REFRESH   = 2'd3
  } fbr_func_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RMW   = 4'b0100,
    ST_REF   = 4'b1000
  } fbr_state_t;

  typedef struct packed {
    fbr_func_t  func;
    logic [6:0] x;
    logic [5:0] y;
  } fbr_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_last;
  } fbr_rsp_t;

endpackage

// ----- src/page_framebuffer_refresh.sv -----
// top level: page-organized frame store with clear, pixel read-modify-write and refresh stream
//
//  channel | dir | payload           | handshake
//  req     | in  | fbr_req_t (func,x,y) | req_valid / req_ready
//  rsp     | out | fbr_rsp_t (byte,flags) | rsp_valid / rsp_ready
//
// set or clear pixel: ram read, then write back; out of range: no store access
// refresh step: ram read for data words, then load of the output register
// clear-all: all DEPTH (1024) entries zeroed, one entry written per cycle, no word accepted
// after reset the same clearing pass runs over all entries before req_ready rises
// a refresh step waits in ST_REF while the output register is still full
module page_framebuffer_refresh (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  fbr_pkg::fbr_req_t req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output fbr_pkg::fbr_rsp_t rsp
);
  import fbr_pkg::*;

  fbr_state_t state;
  fbr_state_t state_next;

  logic [AW-1:0]    clear_cursor;
  logic [PG_W-1:0]  refresh_page;
  logic [POS_W-1:0] refresh_pos;
  logic [AW-1:0]    pend_addr;
  logic [7:0]       pend_mask;
  logic             pend_set;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          accept;
  logic          pix_in_range;
  logic [AW-1:0] pix_addr;
  logic          ref_is_data;
  logic [CW-1:0] ref_col;
  logic          out_free;
  logic          ref_done;
  fbr_rsp_t      ref_word;

  assign accept = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE);
  assign out_free = !rsp_valid || rsp_ready;

  assign pix_in_range = ({1'b0, req.x} < 8'(WIDTH)) && ({1'b0, req.y[5:3]} < 4'(PAGES));
  assign pix_addr = {req.y[3 +: PG_W], req.x[CW-1:0]};

  assign ref_is_data = (refresh_pos >= POS_W'(HEADER_LEN));
  assign ref_col = CW'(refresh_pos - POS_W'(HEADER_LEN));
  assign ref_done = (state == ST_REF) && out_free;

  always_comb begin
    ref_word.is_data = ref_is_data;
    ref_word.frame_last = ref_is_data && (ref_col == CW'(WIDTH - 1))
                          && (refresh_page == PG_W'(PAGES - 1));
    priority if (ref_is_data) begin
      ref_word.out_byte = ram_rdata;
    end else if (refresh_pos == POS_W'(0)) begin
      ref_word.out_byte = 8'(CMD_PAGE_BASE + 8'(refresh_page));
    end else if (refresh_pos == POS_W'(1)) begin
      ref_word.out_byte = CMD_COL_LOW;
    end else begin
      ref_word.out_byte = CMD_COL_HIGH;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = pend_set ? (ram_rdata | pend_mask) : (ram_rdata & ~pend_mask);
    ram_re = 1'b0;
    ram_raddr = pix_addr;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clear_cursor;
        ram_wdata = 8'h00;
        if (clear_cursor == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req.func)
            FUNC_SET, FUNC_CLR: begin
              if (pix_in_range) begin
                ram_re = 1'b1;
                state_next = ST_RMW;
              end
            end
            FUNC_CLEAR_ALL: begin
              state_next = ST_CLEAR;
            end
            FUNC_REFRESH: begin
              ram_re = ref_is_data;
              ram_raddr = {refresh_page, ref_col};
              state_next = ST_REF;
            end
          endcase
        end
      end
      ST_RMW: begin
        ram_we = 1'b1;
        state_next = ST_IDLE;
      end
      ST_REF: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  fbr_ram #(
    .DATA_W(8),
    .RAM_DEPTH(DEPTH)
  ) u_store (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clear_cursor <= '0;
      refresh_page <= '0;
      refresh_pos <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_cursor <= clear_cursor + AW'(1);
      end else begin
        clear_cursor <= '0;
      end
      if (ref_done) begin
        rsp_valid <= 1'b1;
        if (refresh_pos == POS_W'(HEADER_LEN + WIDTH - 1)) begin
          refresh_pos <= '0;
          if (refresh_page == PG_W'(PAGES - 1)) begin
            refresh_page <= '0;
          end else begin
            refresh_page <= refresh_page + PG_W'(1);
          end
        end else begin
          refresh_pos <= refresh_pos + POS_W'(1);
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_addr <= pix_addr;
      pend_mask <= 8'(1) << req.y[2:0];
      pend_set <= (req.func == FUNC_SET);
    end
    if (ref_done) begin
      rsp <= ref_word;
    end
  end

  a_rmw_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW) |=> (state == ST_IDLE))
    else $error("read-modify-write did not return to idle");

  a_clear_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == FUNC_CLEAR_ALL) |=> (state == ST_CLEAR && clear_cursor == '0))
    else $error("clear-all did not start a sweep from entry zero");

  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.frame_last) |-> rsp.is_data)
    else $error("frame_last set on a command word");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("read and write of the same store entry in one cycle");

  a_out_not_lost: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("waiting output word changed or dropped");

endmodule

// ----- src/fbr_ram.sv -----
// generic simple dual-port ram with registered read
module fbr_ram #(
  parameter int DATA_W = 8,
  parameter int RAM_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(RAM_DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]            wdata,
  input  logic                         re,
  input  logic [$clog2(RAM_DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]            rdata
);

  logic [DATA_W-1:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
